FILE: design/bawm_pkg.sv
// Shared types and constants for the bit-addressed word memory.
// Holds the transfer structs, access kind codes and memory port groups.
// No dependencies; every other design file imports this package.
package bawm_pkg;

  // Store geometry.
  localparam int WORD_COUNT = 1024;
  localparam int WIDX_W     = $clog2(WORD_COUNT);
  localparam int WORD_W     = 16;
  localparam int BITPOS_W   = 4;
  localparam int ADDR_W     = 14;
  localparam int DATA_W     = 32;
  localparam int KIND_W     = 3;

  // An access touches at most three stored words, so the window is 48 bits.
  localparam int WIN_W      = 3 * WORD_W;
  localparam int SEG_W      = 2;

  // Word index taken from the bit address, and a width that holds
  // index plus word count for the range check.
  localparam int WBASE_W    = ADDR_W - BITPOS_W;
  localparam int CHK_W      = ((WBASE_W > WIDX_W) ? WBASE_W : WIDX_W) + 2;

  // Access kinds.
  localparam logic [KIND_W-1:0] KIND_RD_BIT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RD_WORD  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RD_DWORD = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WR_BIT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WR_WORD  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_WR_DWORD = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] bit_address;
    logic [DATA_W-1:0] write_data;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              out_of_range;
  } out_t;

  // Control for the shared merge unit: field mask and data already shifted
  // into window position, and which stored word of the window is handled.
  typedef struct packed {
    logic [WIN_W-1:0] mask;
    logic [WIN_W-1:0] data;
    logic [SEG_W-1:0] seg;
  } lane_ctl_t;

  typedef struct packed {
    logic              we;
    logic [WIDX_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              re;
    logic [WIDX_W-1:0] addr;
  } mem_rd_t;

endpackage

FILE: design/bawm_mem.sv
// Word store of the bit-addressed word memory: one write port, one read
// port with registered read data. Depends on bawm_pkg.
module bawm_mem
  import bawm_pkg::*;
(
  input  logic              clk,
  input  mem_wr_t           wr,
  input  mem_rd_t           rd,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [WORD_COUNT];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

FILE: design/bawm_merge_unit.sv
// Shared merge unit: folds the accessed field into one stored word,
// keeping the bits outside the field. Depends on bawm_pkg.
module bawm_merge_unit
  import bawm_pkg::*;
(
  input  lane_ctl_t         ctl,
  input  logic [WORD_W-1:0] old_word,
  output logic [WORD_W-1:0] new_word
);

  logic [WORD_W-1:0] seg_mask;
  logic [WORD_W-1:0] seg_data;

  always_comb begin
    case (ctl.seg)
      2'd0: begin
        seg_mask = ctl.mask[WORD_W-1:0];
        seg_data = ctl.data[WORD_W-1:0];
      end
      2'd1: begin
        seg_mask = ctl.mask[2*WORD_W-1:WORD_W];
        seg_data = ctl.data[2*WORD_W-1:WORD_W];
      end
      2'd2: begin
        seg_mask = ctl.mask[3*WORD_W-1:2*WORD_W];
        seg_data = ctl.data[3*WORD_W-1:2*WORD_W];
      end
      default: begin
        seg_mask = '0;
        seg_data = '0;
      end
    endcase
  end

  assign new_word = (old_word & ~seg_mask) | (seg_data & seg_mask);

endmodule

FILE: design/bit_addressed_word_memory.sv
// Top level of the bit-addressed word memory; instantiates bawm_mem and
// bawm_merge_unit. Depends on bawm_pkg.
//
// The block holds WORD_COUNT words of 16 bits, addressed by bit number, and
// carries out one bit, word or double-word read or write per transfer. An
// access is taken at a rising edge where start is high and busy is low. The
// result is shown on out_item for exactly one cycle, marked by out_valid,
// and the receiver cannot hold it off, so it must take every result in that
// cycle. After reset the block sweeps the store to zero, one word a cycle,
// and holds busy high until the whole store is cleared, before the first access.
// A valid access touches n stored words, n from 1 to 3 (bit: 1; word: 1 when
// aligned, else 2; double word: 2 when aligned, else 3). Busy stays high while
// the sequencer reads the n words, merging them on a write, and passes its
// finishing state; out_valid rises as busy falls, and in that idle cycle the
// next access may already be taken, but no access is taken while busy. This pace
// comes from the registered read of the store and its single write port, which
// the sequencer walks one word a cycle. An access past the end of the store, or
// an unused kind, touches nothing and skips straight to the finishing state;
// the former sets out_of_range. Writes answer with read_data zero.
module bit_addressed_word_memory
  import bawm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RUN,
    ST_FINISH
  } state_t;

  state_t             state_r,    state_nxt;
  logic [WIDX_W-1:0]  clr_idx_r,  clr_idx_nxt;
  logic [CHK_W-1:0]   base_r,     base_nxt;
  logic [BITPOS_W-1:0] bpos_r,    bpos_nxt;
  logic [SEG_W-1:0]   nwords_r,   nwords_nxt;
  logic [SEG_W-1:0]   rd_idx_r,   rd_idx_nxt;
  logic               rv_r,       rv_nxt;
  logic [SEG_W-1:0]   rv_idx_r,   rv_idx_nxt;
  logic               is_write_r, is_write_nxt;
  logic               nop_r,      nop_nxt;
  logic               oor_r,      oor_nxt;
  logic [DATA_W-1:0]  fmask_r,    fmask_nxt;
  logic [WIN_W-1:0]   mask_r,     mask_nxt;
  logic [WIN_W-1:0]   wdata_r,    wdata_nxt;
  logic [WIN_W-1:0]   win_r,      win_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r,      out_nxt;

  // Decode of the incoming access.
  logic [BITPOS_W-1:0] in_bpos;
  logic [CHK_W-1:0]    in_base;
  logic [DATA_W-1:0]   in_fmask;
  logic [SEG_W-1:0]    in_nwords;
  logic                in_nop;
  logic                in_write;
  logic                in_oor;

  // Store ports and merge unit.
  mem_wr_t            mem_wr;
  mem_rd_t            mem_rd;
  logic [WORD_W-1:0]  mem_rdata;
  lane_ctl_t          lane_ctl;
  logic [WORD_W-1:0]  merged_word;
  logic [CHK_W-1:0]   rd_word_idx;
  logic [CHK_W-1:0]   wr_word_idx;
  logic [WIN_W-1:0]   win_shifted;

  assign in_bpos = in_item.bit_address[BITPOS_W-1:0];
  assign in_base = CHK_W'(in_item.bit_address[ADDR_W-1:BITPOS_W]);

  always_comb begin
    in_nop    = 1'b0;
    in_write  = 1'b0;
    in_fmask  = '0;
    in_nwords = 2'd1;
    case (in_item.kind) inside
      KIND_RD_BIT, KIND_WR_BIT: begin
        in_fmask  = DATA_W'(1);
        in_nwords = 2'd1;
      end
      KIND_RD_WORD, KIND_WR_WORD: begin
        in_fmask  = DATA_W'({WORD_W{1'b1}});
        in_nwords = (in_bpos == '0) ? 2'd1 : 2'd2;
      end
      KIND_RD_DWORD, KIND_WR_DWORD: begin
        in_fmask  = '1;
        in_nwords = (in_bpos == '0) ? 2'd2 : 2'd3;
      end
      default: begin
        in_nop = 1'b1;
      end
    endcase
    if (in_item.kind inside {KIND_WR_BIT, KIND_WR_WORD, KIND_WR_DWORD}) begin
      in_write = 1'b1;
    end
  end

  // The access passes the end when its last touched word is beyond the store.
  assign in_oor = !in_nop &&
                  ((in_base + CHK_W'(in_nwords)) > CHK_W'(WORD_COUNT));

  // Read issue runs one word ahead of the merge, which handles the word
  // whose read data has just arrived.
  assign rd_word_idx = base_r + CHK_W'(rd_idx_r);
  assign wr_word_idx = base_r + CHK_W'(rv_idx_r);

  assign mem_rd.re   = (state_r == ST_RUN) && (rd_idx_r < nwords_r);
  assign mem_rd.addr = rd_word_idx[WIDX_W-1:0];

  assign lane_ctl.mask = mask_r;
  assign lane_ctl.data = wdata_r;
  assign lane_ctl.seg  = rv_idx_r;

  always_comb begin
    mem_wr.we   = 1'b0;
    mem_wr.addr = wr_word_idx[WIDX_W-1:0];
    mem_wr.data = merged_word;
    if (state_r == ST_CLEAR) begin
      mem_wr.we   = 1'b1;
      mem_wr.addr = clr_idx_r;
      mem_wr.data = '0;
    end else if (state_r == ST_RUN && rv_r && is_write_r) begin
      mem_wr.we = 1'b1;
    end
  end

  assign win_shifted = win_r >> bpos_r;

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    base_nxt      = base_r;
    bpos_nxt      = bpos_r;
    nwords_nxt    = nwords_r;
    rd_idx_nxt    = rd_idx_r;
    rv_nxt        = rv_r;
    rv_idx_nxt    = rv_idx_r;
    is_write_nxt  = is_write_r;
    nop_nxt       = nop_r;
    oor_nxt       = oor_r;
    fmask_nxt     = fmask_r;
    mask_nxt      = mask_r;
    wdata_nxt     = wdata_r;
    win_nxt       = win_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + WIDX_W'(1);
        if (clr_idx_r == WIDX_W'(WORD_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          base_nxt     = in_base;
          bpos_nxt     = in_bpos;
          nwords_nxt   = in_nwords;
          is_write_nxt = in_write;
          nop_nxt      = in_nop;
          oor_nxt      = in_oor;
          fmask_nxt    = in_fmask;
          mask_nxt     = WIN_W'(in_fmask) << in_bpos;
          wdata_nxt    = WIN_W'(in_item.write_data & in_fmask) << in_bpos;
          win_nxt      = '0;
          rd_idx_nxt   = '0;
          rv_nxt       = 1'b0;
          rv_idx_nxt   = '0;
          state_nxt    = (in_nop || in_oor) ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        rv_nxt     = mem_rd.re;
        rv_idx_nxt = rd_idx_r;
        if (mem_rd.re) begin
          rd_idx_nxt = rd_idx_r + 2'd1;
        end
        if (rv_r) begin
          if (!is_write_r) begin
            case (rv_idx_r)
              2'd0:    win_nxt[WORD_W-1:0]          = mem_rdata;
              2'd1:    win_nxt[2*WORD_W-1:WORD_W]   = mem_rdata;
              2'd2:    win_nxt[3*WORD_W-1:2*WORD_W] = mem_rdata;
              default: win_nxt = win_r;
            endcase
          end
          if (rv_idx_r == nwords_r - 2'd1) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        out_valid_nxt        = 1'b1;
        out_nxt.out_of_range = oor_r;
        if (!is_write_r && !nop_r && !oor_r) begin
          out_nxt.read_data = win_shifted[DATA_W-1:0] & fmask_r;
        end else begin
          out_nxt.read_data = '0;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      rd_idx_r    <= '0;
      rv_r        <= 1'b0;
      rv_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rv_r        <= rv_nxt;
      rv_idx_r    <= rv_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    base_r     <= base_nxt;
    bpos_r     <= bpos_nxt;
    nwords_r   <= nwords_nxt;
    is_write_r <= is_write_nxt;
    nop_r      <= nop_nxt;
    oor_r      <= oor_nxt;
    fmask_r    <= fmask_nxt;
    mask_r     <= mask_nxt;
    wdata_r    <= wdata_nxt;
    win_r      <= win_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  bawm_mem u_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .rd    (mem_rd),
    .rdata (mem_rdata)
  );

  bawm_merge_unit u_merge (
    .ctl      (lane_ctl),
    .old_word (mem_rdata),
    .new_word (merged_word)
  );

endmodule

FILE: design/bawm_checker.sv
// Port-level checks for the bit-addressed word memory, bound to the top.
// Depends on bawm_pkg and on the port list of bit_addressed_word_memory.
module bawm_checker
  import bawm_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input out_t out_item
);

  // Every access holds busy through its finishing state, so the strobe never repeats.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an access transfer");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result shown without a finished access");

  a_range_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.out_of_range) |-> (out_item.read_data == '0))
    else $error("out-of-range result carries data");

endmodule

bind bit_addressed_word_memory bawm_checker u_bawm_checker (.*);
